@@ rtl/pose_joint_angle_features_top_macros.svh @@
// Assertion macros for the joint-angle feature block.
`ifndef POSE_JOINT_ANGLE_FEATURES_TOP_MACROS_SVH
`define POSE_JOINT_ANGLE_FEATURES_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define PJAF_ASSERT_IMPL(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define PJAF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define PJAF_ASSERT_IMPL(lbl, clk, rstn, prop, msg)
`define PJAF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

@@ rtl/pjaf_pkg.sv @@
// Shared types, constants and tables for the joint-angle feature block.
`default_nettype none
package pjaf_pkg;
    localparam int NUM_JOINTS_DEF = 11;
    localparam int COORD_BITS_DEF = 16;
    localparam int CORDIC_STEPS   = 24;
    localparam int FEAT_NUM       = 9;
    localparam int SEG_NUM        = 19;

    typedef enum logic [2:0] {
        ST_LOAD, ST_SEG, ST_ANG, ST_EMIT
    } pjaf_state_t;

    // shared arithmetic unit sequence in the datapath
    typedef enum logic [3:0] {
        U_IDLE, U_RD, U_DIFF, U_SQ, U_SQ2, U_SQRT, U_MUL, U_NORM, U_PROD,
        U_CORD, U_FIN
    } pjaf_unit_t;

    // controller commands and datapath status
    typedef struct packed {
        logic       seg_start;
        logic [4:0] seg_idx;
        logic       ang_start;
        logic [3:0] ang_idx;
        logic       emit_clear;
    } pjaf_cmd_t;

    typedef struct packed {
        logic busy;
        logic ok;
    } pjaf_sts_t;

    function automatic logic [31:0] atan_lut(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'd29491200; 5'd1:  v = 32'd17409672;
            5'd2:  v = 32'd9198793;  5'd3:  v = 32'd4669451;
            5'd4:  v = 32'd2343786;  5'd5:  v = 32'd1173036;
            5'd6:  v = 32'd586661;   5'd7:  v = 32'd293348;
            5'd8:  v = 32'd146676;   5'd9:  v = 32'd73339;
            5'd10: v = 32'd36669;    5'd11: v = 32'd18335;
            5'd12: v = 32'd9167;     5'd13: v = 32'd4584;
            5'd14: v = 32'd2292;     5'd15: v = 32'd1146;
            5'd16: v = 32'd573;      5'd17: v = 32'd286;
            5'd18: v = 32'd143;      5'd19: v = 32'd72;
            5'd20: v = 32'd36;       5'd21: v = 32'd18;
            5'd22: v = 32'd9;        5'd23: v = 32'd4;
            default: v = 32'd0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

@@ rtl/pjaf_ctrl.sv @@
// Sequencer: steps the datapath through segments, angles and emission.
`default_nettype none
module pjaf_ctrl
    import pjaf_pkg::*;
(
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        go,
    input  wire pjaf_sts_t sts,
    input  wire        emit_done,
    output pjaf_cmd_t  cmd,
    output logic       emit_en,
    output logic       loading
);
    pjaf_state_t state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        wait_reg, wait_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            wait_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            wait_reg  <= wait_next;
        end
    end

    // each job is launched, then waited on until the shared unit is idle
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        wait_next  = wait_reg;
        cmd        = '0;
        emit_en    = 1'b0;
        loading    = 1'b0;
        cmd.seg_idx = cnt_reg;
        cmd.ang_idx = cnt_reg[3:0];
        case (state_reg)
            ST_LOAD: begin
                loading = 1'b1;
                cmd.emit_clear = go;
                if (go) begin
                    state_next = ST_SEG;
                    cnt_next = '0;
                    wait_next = 1'b0;
                end
            end
            ST_SEG: begin
                if (!wait_reg) begin
                    cmd.seg_start = 1'b1;
                    wait_next = 1'b1;
                end else if (!sts.busy) begin
                    wait_next = 1'b0;
                    if (cnt_reg == 5'(SEG_NUM - 1)) begin
                        state_next = ST_ANG;
                        cnt_next = '0;
                    end else begin
                        cnt_next = cnt_reg + 5'd1;
                    end
                end
            end
            ST_ANG: begin
                if (!wait_reg) begin
                    cmd.ang_start = 1'b1;
                    wait_next = 1'b1;
                end else if (!sts.busy) begin
                    wait_next = 1'b0;
                    if (cnt_reg == 5'd7) begin
                        state_next = sts.ok ? ST_EMIT : ST_LOAD;
                        cnt_next = '0;
                    end else begin
                        cnt_next = cnt_reg + 5'd1;
                    end
                end
            end
            ST_EMIT: begin
                emit_en = 1'b1;
                if (emit_done) state_next = ST_LOAD;
            end
            default: state_next = ST_LOAD;
        endcase
    end
endmodule
`default_nettype wire

@@ rtl/pjaf_datapath.sv @@
// Datapath: joint store, shared multiply, square root and CORDIC unit.
`default_nettype none
module pjaf_datapath
    import pjaf_pkg::*;
#(
    parameter int NUM_JOINTS = NUM_JOINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  wr_en,
    input  wire [3:0]            wr_id,
    input  wire [COORD_BITS-1:0] wr_x,
    input  wire [COORD_BITS-1:0] wr_y,
    input  wire [COORD_BITS-1:0] wr_z,
    input  wire pjaf_cmd_t       cmd,
    output pjaf_sts_t            sts,
    input  wire                  emit_en,
    input  wire                  emit_take,
    output logic                 emit_valid,
    output logic [3:0]           emit_id,
    output logic [16:0]          emit_value,
    output logic                 emit_last,
    output logic                 emit_done
);
    localparam int LF  = 28 - COORD_BITS;
    localparam int CW  = COORD_BITS + 2;
    localparam int IDW = $clog2(NUM_JOINTS);

    // joint store
    logic signed [COORD_BITS-1:0] jx_mem [NUM_JOINTS];
    logic signed [COORD_BITS-1:0] jy_mem [NUM_JOINTS];
    logic signed [COORD_BITS-1:0] jz_mem [NUM_JOINTS];

    always_ff @(posedge aclk) begin
        if (wr_en && ({28'd0, wr_id} < NUM_JOINTS)) begin
            jx_mem[wr_id[IDW-1:0]] <= wr_x;
            jy_mem[wr_id[IDW-1:0]] <= wr_y;
            jz_mem[wr_id[IDW-1:0]] <= wr_z;
        end
    end

    // segment lengths, index order: a b c d e f g h i j k l m n r s t u v
    logic [31:0] len_reg [SEG_NUM];
    logic signed [16:0] feat_reg [FEAT_NUM];
    logic        ok_reg;

    // unit state
    pjaf_unit_t u_reg;
    logic [4:0]  job_reg;
    logic        is_ang_reg;
    logic [1:0]  sub_reg;
    logic signed [CW-1:0] dx_reg, dy_reg, dz_reg;
    logic [127:0] acc_reg;
    logic [63:0]  rad_reg, root_reg, bit_reg;
    logic [63:0]  mag_reg, den_reg;
    logic         neg_reg;
    logic signed [63:0] cx_reg, cy_reg, cz_reg;
    logic [4:0]   it_reg;
    logic [63:0]  mula_reg, mulb_reg;
    logic [63:0]  p_reg, q_reg, o_reg;

    function automatic logic [4:0] pa(input logic [4:0] j);
        logic [4:0] v;
        case (j)
            5'd0: v = 5'd3;  5'd1: v = 5'd1;  5'd2: v = 5'd1;  5'd3: v = 5'd4;
            5'd4: v = 5'd1;  5'd5: v = 5'd1;  5'd6: v = 5'd3;  5'd7: v = 5'd5;
            5'd8: v = 5'd4;  5'd9: v = 5'd6;  5'd10: v = 5'd5; 5'd11: v = 5'd7;
            5'd12: v = 5'd6; 5'd13: v = 5'd8; 5'd14: v = 5'd1; 5'd15: v = 5'd2;
            5'd16: v = 5'd2; 5'd17: v = 5'd2; 5'd18: v = 5'd1; default: v = 5'd0;
        endcase
        return v;
    endfunction
    function automatic logic [4:0] pb(input logic [4:0] j);
        logic [4:0] v;
        case (j)
            5'd0: v = 5'd5;  5'd1: v = 5'd3;  5'd2: v = 5'd5;  5'd3: v = 5'd6;
            5'd4: v = 5'd4;  5'd5: v = 5'd6;  5'd6: v = 5'd7;  5'd7: v = 5'd7;
            5'd8: v = 5'd8;  5'd9: v = 5'd8;  5'd10: v = 5'd9; 5'd11: v = 5'd9;
            5'd12: v = 5'd10; 5'd13: v = 5'd10; 5'd14: v = 5'd2; 5'd15: v = 5'd1;
            5'd16: v = 5'd1; 5'd17: v = 5'd5; 5'd18: v = 5'd5; default: v = 5'd0;
        endcase
        return v;
    endfunction
    // angle operands (p, q, o) as length indexes
    function automatic logic [14:0] aop(input logic [3:0] j);
        logic [14:0] v;
        case (j)
            4'd0: v = {5'd0, 5'd1, 5'd2};   4'd1: v = {5'd4, 5'd3, 5'd5};
            4'd2: v = {5'd0, 5'd7, 5'd6};   4'd3: v = {5'd3, 5'd9, 5'd8};
            4'd4: v = {5'd16, 5'd15, 5'd14}; 4'd5: v = {5'd16, 5'd18, 5'd17};
            4'd6: v = {5'd9, 5'd13, 5'd12}; 4'd7: v = {5'd7, 5'd11, 5'd10};
            default: v = '0;
        endcase
        return v;
    endfunction

    logic [4:0] ja, jb;
    logic [14:0] ops;
    assign ja = pa(job_reg);
    assign jb = pb(job_reg);
    assign ops = aop(job_reg[3:0]);

    // registered reads of the joint store
    logic signed [COORD_BITS-1:0] rax_reg, ray_reg, raz_reg, rbx_reg, rby_reg, rbz_reg;
    logic signed [COORD_BITS-1:0] k5x_reg, k5y_reg, k5z_reg, k6x_reg, k6y_reg, k6z_reg;
    logic signed [COORD_BITS-1:0] hy0_reg, hy7_reg, hy8_reg;
    always_ff @(posedge aclk) begin
        rax_reg <= jx_mem[ja[IDW-1:0]];
        ray_reg <= jy_mem[ja[IDW-1:0]];
        raz_reg <= jz_mem[ja[IDW-1:0]];
        rbx_reg <= jx_mem[jb[IDW-1:0]];
        rby_reg <= jy_mem[jb[IDW-1:0]];
        rbz_reg <= jz_mem[jb[IDW-1:0]];
        k5x_reg <= jx_mem[5];
        k5y_reg <= jy_mem[5];
        k5z_reg <= jz_mem[5];
        k6x_reg <= jx_mem[6];
        k6y_reg <= jy_mem[6];
        k6z_reg <= jz_mem[6];
        hy0_reg <= jy_mem[0];
        hy7_reg <= jy_mem[7];
        hy8_reg <= jy_mem[8];
    end

    logic signed [CW-1:0] ax, ay, az, bx, by, bz, cx5, cy5, cz5, cx6, cy6, cz6;
    always_comb begin
        ax = CW'(rax_reg); ay = CW'(ray_reg); az = CW'(raz_reg);
        bx = CW'(rbx_reg); by = CW'(rby_reg); bz = CW'(rbz_reg);
        cx5 = CW'(k5x_reg); cy5 = CW'(k5y_reg); cz5 = CW'(k5z_reg);
        cx6 = CW'(k6x_reg); cy6 = CW'(k6y_reg); cz6 = CW'(k6z_reg);
    end

    // one multiplier, shared by all squaring and product steps
    logic [63:0] mul_out;
    assign mul_out = mula_reg[31:0] * mulb_reg[31:0];

    logic [CW-1:0] adx, ady, adz;
    assign adx = dx_reg[CW-1] ? CW'(-dx_reg) : CW'(dx_reg);
    assign ady = dy_reg[CW-1] ? CW'(-dy_reg) : CW'(dy_reg);
    assign adz = dz_reg[CW-1] ? CW'(-dz_reg) : CW'(dz_reg);

    logic [63:0] trial;
    assign trial = root_reg + bit_reg;
    logic signed [63:0] sx, sy;
    assign sx = cy_reg >>> it_reg;
    assign sy = cx_reg >>> it_reg;

    assign sts.busy = (u_reg != U_IDLE);
    assign sts.ok   = ok_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            u_reg  <= U_IDLE;
            ok_reg <= 1'b1;
        end else begin
            if (cmd.emit_clear) ok_reg <= 1'b1;
            case (u_reg)
                U_IDLE: begin
                    if (cmd.seg_start) begin
                        job_reg <= cmd.seg_idx;
                        is_ang_reg <= 1'b0;
                        u_reg <= U_RD;
                    end else if (cmd.ang_start) begin
                        job_reg <= {1'b0, cmd.ang_idx};
                        is_ang_reg <= 1'b1;
                        u_reg <= U_MUL;
                        sub_reg <= '0;
                        acc_reg <= '0;
                    end
                end
                // joint store read for the current segment
                U_RD: begin
                    u_reg <= U_DIFF;
                end
                // coordinate differences for the current segment
                U_DIFF: begin
                    if (job_reg == 5'd18 || job_reg == 5'd17) begin
                        dx_reg <= CW'((ax <<< 1) - cx5 - cx6);
                        dy_reg <= CW'((ay <<< 1) - cy5 - cy6);
                        dz_reg <= CW'((az <<< 1) - cz5 - cz6);
                    end else begin
                        dx_reg <= ax - bx;
                        dy_reg <= ay - by;
                        dz_reg <= az - bz;
                    end
                    acc_reg <= '0;
                    sub_reg <= '0;
                    u_reg   <= U_SQ;
                end
                // squares of the coordinate differences accumulated
                U_SQ: begin
                    case (sub_reg)
                        2'd0: begin mula_reg <= 64'(adx); mulb_reg <= 64'(adx); end
                        2'd1: begin
                            acc_reg <= acc_reg + 128'(mul_out);
                            mula_reg <= 64'(ady); mulb_reg <= 64'(ady);
                        end
                        2'd2: begin
                            if (job_reg != 5'd14 && job_reg != 5'd15)
                                acc_reg <= acc_reg + 128'(mul_out);
                            else if (job_reg == 5'd15)
                                den_reg <= mul_out;
                            mula_reg <= 64'(adz); mulb_reg <= 64'(adz);
                        end
                        default: begin
                            if (job_reg == 5'd15)
                                acc_reg <= 128'(len_reg[14]) << LF;
                            else
                                acc_reg <= acc_reg + 128'(mul_out);
                        end
                    endcase
                    if (sub_reg == 2'd3) u_reg <= U_SQ2;
                    sub_reg <= sub_reg + 2'd1;
                end
                // scale to the length format
                U_SQ2: begin
                    if (job_reg == 5'd15)
                        rad_reg <= 64'(acc_reg) + (den_reg << (2 * LF));
                    else if (job_reg >= 5'd17)
                        rad_reg <= 64'(acc_reg << (2 * LF - 2));
                    else
                        rad_reg <= 64'(acc_reg << (2 * LF));
                    root_reg <= '0;
                    bit_reg  <= 64'd1 << 62;
                    u_reg    <= U_SQRT;
                end
                // bit-pair square root, one step per cycle
                U_SQRT: begin
                    if (bit_reg == 64'd0) begin
                        if (is_ang_reg) begin
                            u_reg <= U_CORD;
                            it_reg <= '0;
                            if (neg_reg) begin
                                cx_reg <= $signed(root_reg); cy_reg <= $signed(mag_reg);
                                cz_reg <= 64'sd900 * 64'sd65536;
                            end else begin
                                cx_reg <= $signed(mag_reg); cy_reg <= $signed(root_reg);
                                cz_reg <= '0;
                            end
                        end else begin
                            len_reg[job_reg] <= root_reg[31:0];
                            u_reg <= U_IDLE;
                        end
                    end else begin
                        if (bit_reg > rad_reg && root_reg == 64'd0) begin
                            bit_reg <= bit_reg >> 2;
                        end else if (rad_reg >= trial) begin
                            rad_reg  <= rad_reg - trial;
                            root_reg <= (root_reg >> 1) + bit_reg;
                            bit_reg  <= bit_reg >> 2;
                        end else begin
                            root_reg <= root_reg >> 1;
                            bit_reg  <= bit_reg >> 2;
                        end
                    end
                end
                // law of cosines terms: p*p, q*q, o*o, p*q
                U_MUL: begin
                    case (sub_reg)
                        2'd0: begin
                            p_reg <= 64'(len_reg[ops[14:10]]);
                            q_reg <= 64'(len_reg[ops[9:5]]);
                            o_reg <= 64'(len_reg[ops[4:0]]);
                            mula_reg <= 64'(len_reg[ops[14:10]]);
                            mulb_reg <= 64'(len_reg[ops[14:10]]);
                        end
                        2'd1: begin
                            acc_reg <= 128'(mul_out);
                            mula_reg <= q_reg; mulb_reg <= q_reg;
                        end
                        2'd2: begin
                            acc_reg <= acc_reg + 128'(mul_out);
                            mula_reg <= o_reg; mulb_reg <= o_reg;
                        end
                        default: begin
                            acc_reg <= acc_reg - 128'(mul_out);
                            mula_reg <= p_reg; mulb_reg <= q_reg;
                            u_reg <= U_NORM;
                        end
                    endcase
                    sub_reg <= sub_reg + 2'd1;
                end
                // magnitude check and normalisation into [2^29, 2^31)
                U_NORM: begin
                    if (sub_reg == 2'd0) begin
                        den_reg <= mul_out << 1;
                        neg_reg <= acc_reg[127];
                        mag_reg <= acc_reg[127] ? 64'(-acc_reg) : 64'(acc_reg);
                        sub_reg <= 2'd1;
                    end else if (den_reg == 64'd0 || mag_reg > den_reg) begin
                        ok_reg <= 1'b0;
                        u_reg  <= U_IDLE;
                    end else if (den_reg >= (64'd1 << 31)) begin
                        den_reg <= den_reg >> 1; mag_reg <= mag_reg >> 1;
                    end else if (den_reg < (64'd1 << 29)) begin
                        den_reg <= den_reg << 1; mag_reg <= mag_reg << 1;
                    end else begin
                        mula_reg <= den_reg - mag_reg;
                        mulb_reg <= den_reg + mag_reg;
                        u_reg <= U_PROD;
                    end
                end
                U_PROD: begin
                    rad_reg  <= mul_out;
                    root_reg <= '0;
                    bit_reg  <= 64'd1 << 62;
                    u_reg    <= U_SQRT;
                end
                // CORDIC vectoring, one step per cycle
                U_CORD: begin
                    if (it_reg == 5'(CORDIC_STEPS)) begin
                        u_reg <= U_FIN;
                    end else begin
                        if (cy_reg > 0) begin
                            cx_reg <= cx_reg + sx; cy_reg <= cy_reg - sy;
                            cz_reg <= cz_reg + $signed(64'(atan_lut(it_reg)));
                        end else begin
                            cx_reg <= cx_reg - sx; cy_reg <= cy_reg + sy;
                            cz_reg <= cz_reg - $signed(64'(atan_lut(it_reg)));
                        end
                        it_reg <= it_reg + 5'd1;
                    end
                end
                U_FIN: begin
                    if (cz_reg < 0) begin
                        cz_reg <= '0;
                    end else if (cz_reg > 64'sd1800 * 64'sd65536) begin
                        cz_reg <= 64'sd1800 * 64'sd65536;
                    end else begin
                        case (job_reg[3:0])
                            4'd4: feat_reg[5] <= 17'(1800 - ((cz_reg + 32768) >>> 16));
                            default: feat_reg[job_reg[3:0] + 4'd1] <=
                                17'((cz_reg + 32768) >>> 16);
                        endcase
                        u_reg <= U_IDLE;
                    end
                end
                default: u_reg <= U_IDLE;
            endcase
        end
    end

    // height and emission counter
    logic signed [COORD_BITS:0] lo_y;
    logic signed [COORD_BITS+1:0] hgt;
    assign lo_y = (hy7_reg < hy8_reg) ? (COORD_BITS+1)'(hy7_reg)
                                      : (COORD_BITS+1)'(hy8_reg);
    assign hgt  = (COORD_BITS+2)'(hy0_reg) - (COORD_BITS+2)'(lo_y);

    logic [3:0] ecnt_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) ecnt_reg <= '0;
        else if (cmd.emit_clear) ecnt_reg <= '0;
        else if (emit_en && emit_take) ecnt_reg <= ecnt_reg + 4'd1;
    end

    logic signed [16:0] h_sat;
    always_comb begin
        if (hgt > 65535) h_sat = 17'sd65535;
        else if (hgt < -65536) h_sat = -17'sd65536;
        else h_sat = 17'(hgt);
    end

    assign emit_valid = emit_en;
    assign emit_id    = ecnt_reg;
    assign emit_value = (ecnt_reg == 4'd0) ? h_sat : feat_reg[ecnt_reg];
    assign emit_last  = (ecnt_reg == 4'(FEAT_NUM - 1));
    assign emit_done  = emit_en && emit_take && emit_last;
endmodule
`default_nettype wire

@@ rtl/pose_joint_angle_features_top.sv @@
// Top level of the joint-angle feature block.
// Input beats carry one joint each: tdata = {pos_z, pos_y, pos_x, joint_id},
// tlast marks the frame end. While features are computed the input stalls.
// On tlast the block computes 19 segment lengths through the shared
// square-root unit and 8 angles (normalisation, square root and 24
// CORDIC steps, with a data-dependent number of normalisation shifts),
// then presents 9 output beats, one per cycle while accepted: tdata =
// {feature_value, feature_id}, tlast on the ninth. A dropped frame gives
// no beats. Non-final joints are accepted whenever the block is loading.
// The output holds while m_axis_tready is low. Reset returns the
// sequencer to loading; the joint store is undefined until written.
`default_nettype none
`include "pose_joint_angle_features_top_macros.svh"
module pose_joint_angle_features_top
    import pjaf_pkg::*;
#(
    parameter int NUM_JOINTS = NUM_JOINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // joint_id[3:0], pos_x, pos_y, pos_z, zero padding
    input  wire [((4+3*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  wire         s_axis_tlast,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // feature_id[3:0], feature_value[20:4], zero padding to 24
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    pjaf_cmd_t cmd;
    pjaf_sts_t sts;
    logic emit_en, emit_done, loading, acc_in, ev, el;
    logic [3:0] eid;
    logic [16:0] eval_w;
    logic out_last_take;

    assign s_axis_tready = loading;
    assign acc_in = s_axis_tvalid && s_axis_tready;

    pjaf_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .go(acc_in && s_axis_tlast), .sts(sts),
        .emit_done(emit_done), .cmd(cmd), .emit_en(emit_en), .loading(loading)
    );

    pjaf_datapath #(.NUM_JOINTS(NUM_JOINTS), .COORD_BITS(COORD_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .wr_en(acc_in),
        .wr_id(s_axis_tdata[3:0]),
        .wr_x(s_axis_tdata[4 +: COORD_BITS]),
        .wr_y(s_axis_tdata[4+COORD_BITS +: COORD_BITS]),
        .wr_z(s_axis_tdata[4+2*COORD_BITS +: COORD_BITS]),
        .cmd(cmd), .sts(sts), .emit_en(emit_en), .emit_take(m_axis_tready),
        .emit_valid(ev), .emit_id(eid), .emit_value(eval_w), .emit_last(el),
        .emit_done(emit_done)
    );

    assign m_axis_tvalid = ev;
    assign m_axis_tdata  = {3'd0, eval_w, eid};
    assign m_axis_tlast  = el;

    // last feature beat accepted
    assign out_last_take = m_axis_tvalid && m_axis_tready && m_axis_tlast;

    `PJAF_ASSERT_IMPL(a_no_in_out, aclk, aresetn, !(m_axis_tvalid && s_axis_tready), "in while out")
    `PJAF_ASSERT_NEXT(a_last_end, aclk, aresetn, out_last_take, !m_axis_tvalid, "beat after last")
endmodule
`default_nettype wire
